[sv/mcs_pkg.sv]
// shared types, constants and helper functions for the timer and interrupt unit
package mcs_pkg;

  localparam int unsigned STACK_DEPTH = 5;
  localparam int unsigned SRC_COUNT   = 5;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IE_GLOBAL   = 7;

  typedef enum logic [2:0] {
    SRC_EXT0 = 3'd0,
    SRC_EXT1 = 3'd1,
    SRC_T0   = 3'd2,
    SRC_T1   = 3'd3,
    SRC_T2   = 3'd4
  } src_e;

  typedef enum logic [2:0] {
    CFG_TIMER_MODE  = 3'd0,
    CFG_RUN_ENABLES = 3'd1,
    CFG_EDGE_SELECT = 3'd2,
    CFG_INT_ENABLE  = 3'd3,
    CFG_T2_RELOAD   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TMODE_13BIT  = 2'd0,
    TMODE_16BIT  = 2'd1,
    TMODE_RELOAD = 2'd2,
    TMODE_SPLIT  = 2'd3
  } tmode_e;

  localparam logic [5:0] VEC_EXT0 = 6'h03;
  localparam logic [5:0] VEC_T0   = 6'h0B;
  localparam logic [5:0] VEC_EXT1 = 6'h13;
  localparam logic [5:0] VEC_T1   = 6'h1B;
  localparam logic [5:0] VEC_T2   = 6'h2B;

  // ie register bit positions per source
  localparam logic [2:0] IE_EXT0 = 3'd0;
  localparam logic [2:0] IE_T0   = 3'd1;
  localparam logic [2:0] IE_EXT1 = 3'd2;
  localparam logic [2:0] IE_T1   = 3'd3;
  localparam logic [2:0] IE_T2   = 3'd5;

  typedef struct packed {
    logic [3:0] cycles;
    logic       int0_pin;
    logic       int1_pin;
    logic       reti;
    logic       clear_timer2_flag;
  } in_t;

  typedef struct packed {
    logic [4:0]  accepted_mask;
    logic [5:0]  top_vector;
    logic [4:0]  pending_flags;
    logic [15:0] timer0_value;
    logic [15:0] timer1_value;
    logic [15:0] timer2_value;
    logic        mode_error;
  } out_t;

  typedef struct packed {
    logic       step;
    logic [1:0] pins;
    logic       reti;
    logic       clear_t2;
    logic [2:0] ovf;
  } irq_evt_t;

  typedef struct packed {
    logic [4:0] acc_mask;
    logic [5:0] top_vector;
    logic [4:0] flags;
  } irq_res_t;

  function automatic logic [5:0] vector_of(input logic [2:0] src);
    logic [5:0] v;
    begin
      case (src)
        SRC_EXT0: v = VEC_EXT0;
        SRC_EXT1: v = VEC_EXT1;
        SRC_T0:   v = VEC_T0;
        SRC_T1:   v = VEC_T1;
        SRC_T2:   v = VEC_T2;
        default:  v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [2:0] ie_bit_of(input logic [2:0] src);
    logic [2:0] b;
    begin
      case (src)
        SRC_EXT0: b = IE_EXT0;
        SRC_EXT1: b = IE_EXT1;
        SRC_T0:   b = IE_T0;
        SRC_T1:   b = IE_T1;
        SRC_T2:   b = IE_T2;
        default:  b = IE_EXT0;
      endcase
      return b;
    end
  endfunction

endpackage

[sv/mcs_timer01.sv]
// next-count logic for timer 0 or timer 1 (13-bit, 16-bit, 8-bit auto-reload; other modes flag an error)
module mcs_timer01 (
  input  logic [15:0] count_i,
  input  logic [3:0]  mode_i,
  input  logic        run_i,
  input  logic [3:0]  cycles_i,
  output logic [15:0] count_o,
  output logic        ovf_o,
  output logic        err_o
);

  logic [7:0]  lo, hi;
  logic [13:0] sum13;
  logic [16:0] sum16;
  logic [8:0]  sum8;
  logic [7:0]  reload_lo;

  assign lo        = count_i[7:0];
  assign hi        = count_i[15:8];
  assign sum13     = {1'b0, hi, lo[4:0]} + {10'd0, cycles_i};
  assign sum16     = {1'b0, count_i} + {13'd0, cycles_i};
  assign sum8      = {1'b0, lo} + {5'd0, cycles_i};
  assign reload_lo = sum8[7:0] + hi;

  always_comb begin
    count_o = count_i;
    ovf_o   = 1'b0;
    err_o   = 1'b0;
    if (run_i) begin
      if (mode_i[3] || mode_i[2] || (mode_i[1:0] == mcs_pkg::TMODE_SPLIT)) begin
        err_o = 1'b1;
      end else begin
        unique case (mode_i[1:0])
          mcs_pkg::TMODE_13BIT: begin
            count_o = {sum13[12:5], lo[7:5], sum13[4:0]};
            ovf_o   = sum13[13];
          end
          mcs_pkg::TMODE_16BIT: begin
            count_o = sum16[15:0];
            ovf_o   = sum16[16];
          end
          mcs_pkg::TMODE_RELOAD: begin
            count_o = {hi, sum8[8] ? reload_lo : sum8[7:0]};
            ovf_o   = sum8[8];
          end
          default: begin
            count_o = count_i;
          end
        endcase
      end
    end
  end

endmodule

[sv/mcs_irq.sv]
// interrupt flags, pin qualification, priority vectoring and in-service stack
module mcs_irq #(
  parameter int unsigned STACK_DEPTH = mcs_pkg::STACK_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcs_pkg::irq_evt_t  evt_i,
  input  logic [7:0]         int_enable_i,
  input  logic [1:0]         edge_select_i,
  output mcs_pkg::irq_res_t  res_o
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);

  logic [4:0]    flags_q, flags_d;
  logic [1:0]    prev_pins_q;
  logic [4:0]    insvc_q, insvc_d;
  logic [LW-1:0] level_q, level_d;
  logic [2:0]    stack_q [STACK_DEPTH];
  logic [2:0]    stack_d [STACK_DEPTH];

  always_comb begin
    logic [2:0] pop_src;
    logic [4:0] mask;
    logic [5:0] vec;
    flags_d = flags_q;
    insvc_d = insvc_q;
    level_d = level_q;
    stack_d = stack_q;
    mask    = '0;
    vec     = '0;
    pop_src = '0;
    if (evt_i.reti && (level_q != '0)) begin
      level_d = level_q - 1'b1;
      pop_src = stack_q[level_d[IW-1:0]];
      if (pop_src < 3'(mcs_pkg::SRC_COUNT)) begin
        insvc_d = insvc_d & ~(5'd1 << pop_src);
      end
    end
    if (evt_i.clear_t2) begin
      flags_d[mcs_pkg::SRC_T2] = 1'b0;
    end
    for (int n = 0; n < 2; n++) begin
      if (!evt_i.pins[n] && (!edge_select_i[n] || prev_pins_q[n])) begin
        flags_d[n] = 1'b1;
      end
    end
    flags_d[mcs_pkg::SRC_T0] = flags_d[mcs_pkg::SRC_T0] | evt_i.ovf[0];
    flags_d[mcs_pkg::SRC_T1] = flags_d[mcs_pkg::SRC_T1] | evt_i.ovf[1];
    flags_d[mcs_pkg::SRC_T2] = flags_d[mcs_pkg::SRC_T2] | evt_i.ovf[2];
    // fixed order: ext0, ext1, t0, t1, t2
    for (int s = 0; s < int'(mcs_pkg::SRC_COUNT); s++) begin
      if (flags_d[s] && int_enable_i[mcs_pkg::IE_GLOBAL]
          && int_enable_i[mcs_pkg::ie_bit_of(3'(s))] && !insvc_d[s]
          && (level_d < LW'(STACK_DEPTH))) begin
        insvc_d[s]                = 1'b1;
        stack_d[level_d[IW-1:0]]  = 3'(s);
        level_d                   = level_d + 1'b1;
        mask[s]                   = 1'b1;
        vec                       = mcs_pkg::vector_of(3'(s));
        if (3'(s) != mcs_pkg::SRC_T2) begin
          flags_d[s] = 1'b0;
        end
      end
    end
    res_o.acc_mask   = mask;
    res_o.top_vector = vec;
    res_o.flags      = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      prev_pins_q <= '1;
      insvc_q     <= '0;
      level_q     <= '0;
    end else if (evt_i.step) begin
      flags_q     <= flags_d;
      prev_pins_q <= evt_i.pins;
      insvc_q     <= insvc_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.step) begin
      stack_q <= stack_d;
    end
  end

endmodule

[sv/mcs51_timers_and_interrupts.sv]
// top level: request register, timer and interrupt update, result register
// Each request is one executed instruction. It is taken into a request
// register; once the result register is free or being read, the timers,
// interrupt flags and in-service stack are updated in a single pass and
// the result is loaded into the result register. One request is accepted
// every cycle; the sustained rate of one per cycle is set by the single
// state-update stage, and it holds as long as results are taken.
// Configuration writes take effect at once; the user must make them while idle (not enforced).
module mcs51_timers_and_interrupts #(
  parameter int unsigned STACK_DEPTH = mcs_pkg::STACK_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mcs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [mcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mcs_pkg::in_t                     in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mcs_pkg::out_t                    out_o
);

  logic [7:0]  timer_mode_q;
  logic [2:0]  run_enables_q;
  logic [1:0]  edge_select_q;
  logic [7:0]  int_enable_q;
  logic [15:0] t2_reload_q;

  mcs_pkg::in_t  req_q;
  logic          req_vld_q;
  mcs_pkg::out_t out_q;
  logic          out_vld_q;
  logic          step;

  logic [15:0] count0_q, count1_q, count2_q;
  logic [15:0] count0_d, count1_d, count2_d;
  logic        ovf0, ovf1, ovf2, err0, err1;
  logic [16:0] t2_sum;

  mcs_pkg::irq_evt_t irq_evt;
  mcs_pkg::irq_res_t irq_res;

  assign step       = req_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_mode_q  <= '0;
      run_enables_q <= '0;
      edge_select_q <= '0;
      int_enable_q  <= '0;
      t2_reload_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mcs_pkg::CFG_TIMER_MODE:  timer_mode_q  <= cfg_data_i[7:0];
        mcs_pkg::CFG_RUN_ENABLES: run_enables_q <= cfg_data_i[2:0];
        mcs_pkg::CFG_EDGE_SELECT: edge_select_q <= cfg_data_i[1:0];
        mcs_pkg::CFG_INT_ENABLE:  int_enable_q  <= cfg_data_i[7:0];
        mcs_pkg::CFG_T2_RELOAD:   t2_reload_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_i;
    end
  end

  mcs_timer01 u_timer0 (
    .count_i  (count0_q),
    .mode_i   (timer_mode_q[3:0]),
    .run_i    (run_enables_q[0]),
    .cycles_i (req_q.cycles),
    .count_o  (count0_d),
    .ovf_o    (ovf0),
    .err_o    (err0)
  );

  mcs_timer01 u_timer1 (
    .count_i  (count1_q),
    .mode_i   (timer_mode_q[7:4]),
    .run_i    (run_enables_q[1]),
    .cycles_i (req_q.cycles),
    .count_o  (count1_d),
    .ovf_o    (ovf1),
    .err_o    (err1)
  );

  // timer 2: wrap, then add the reload on overflow
  assign t2_sum   = {1'b0, count2_q} + {13'd0, req_q.cycles};
  assign ovf2     = run_enables_q[2] && t2_sum[16];
  assign count2_d = !run_enables_q[2] ? count2_q
                  : (t2_sum[16] ? t2_sum[15:0] + t2_reload_q : t2_sum[15:0]);

  assign irq_evt.step     = step;
  assign irq_evt.pins     = {req_q.int1_pin, req_q.int0_pin};
  assign irq_evt.reti     = req_q.reti;
  assign irq_evt.clear_t2 = req_q.clear_timer2_flag;
  assign irq_evt.ovf      = {ovf2, ovf1, ovf0};

  mcs_irq #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_irq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_i         (irq_evt),
    .int_enable_i  (int_enable_q),
    .edge_select_i (edge_select_q),
    .res_o         (irq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count0_q  <= '0;
      count1_q  <= '0;
      count2_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (step) begin
        count0_q  <= count0_d;
        count1_q  <= count1_d;
        count2_q  <= count2_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.accepted_mask <= irq_res.acc_mask;
      out_q.top_vector    <= irq_res.top_vector;
      out_q.pending_flags <= irq_res.flags;
      out_q.timer0_value  <= count0_d;
      out_q.timer1_value  <= count1_d;
      out_q.timer2_value  <= count2_d;
      out_q.mode_error    <= err0 || err1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  a_vec_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.top_vector == '0) == (out_q.accepted_mask == '0)))
    else $error("vector and accepted mask disagree");

  a_accept_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (((out_q.accepted_mask[3:0] & out_q.pending_flags[3:0]) == '0)
                   && (!out_q.accepted_mask[4] || out_q.pending_flags[4])))
    else $error("accepted source left with wrong flag state");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("request processed without result");

endmodule

[verif/tb_mcs51_timers_and_interrupts.sv]
// testbench for the 8051-style timer and interrupt unit: self-checking against a built-in predictor
`timescale 1ns / 100ps

module tb_mcs51_timers_and_interrupts;

  localparam int unsigned IDX_W = mcs_pkg::CFG_INDEX_W;
  localparam int IDX_UNMAPPED = int'(mcs_pkg::CFG_T2_RELOAD) + 1;
  localparam int IDX_TOP      = (1 << mcs_pkg::CFG_INDEX_W) - 1;
  localparam int REPORT_CAP   = 100;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [mcs_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [mcs_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  mcs_pkg::in_t                    in_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  mcs_pkg::out_t                   out_o;

  mcs51_timers_and_interrupts dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register shadows
  logic [7:0]  sh_tmod;
  logic [2:0]  sh_run;
  logic [1:0]  sh_edge;
  logic [7:0]  sh_ie;
  logic [15:0] sh_reload;

  // predicted unit state
  logic [15:0] cnt0, cnt1, cnt2;
  logic [4:0]  flags, in_svc, acc;
  logic [1:0]  prev_pins;
  logic [5:0]  top_vec;
  logic [2:0]  svc_stack [mcs_pkg::STACK_DEPTH];
  int unsigned stk_lvl;

  mcs_pkg::out_t exp_results [$];
  mcs_pkg::out_t want;

  int send_idle_pct, recv_idle_pct;
  int fail_count, n_sent, n_cfg, n_vectored, n_ovf, n_mode_err;
  logic pin0_last, pin1_last;

  function automatic void accept_source(input mcs_pkg::src_e s);
    logic [4:0] b;
    logic [2:0] ie_b;
    logic [5:0] vec;
    b = 5'b1 << s;
    case (s)
      mcs_pkg::SRC_EXT0: begin ie_b = mcs_pkg::IE_EXT0; vec = mcs_pkg::VEC_EXT0; end
      mcs_pkg::SRC_EXT1: begin ie_b = mcs_pkg::IE_EXT1; vec = mcs_pkg::VEC_EXT1; end
      mcs_pkg::SRC_T0:   begin ie_b = mcs_pkg::IE_T0;   vec = mcs_pkg::VEC_T0;   end
      mcs_pkg::SRC_T1:   begin ie_b = mcs_pkg::IE_T1;   vec = mcs_pkg::VEC_T1;   end
      default:           begin ie_b = mcs_pkg::IE_T2;   vec = mcs_pkg::VEC_T2;   end
    endcase
    if ((flags & b) != 0 && sh_ie[mcs_pkg::IE_GLOBAL] && sh_ie[ie_b] && (in_svc & b) == 0 &&
        stk_lvl < mcs_pkg::STACK_DEPTH) begin
      in_svc |= b;
      svc_stack[stk_lvl] = s;
      stk_lvl++;
      acc |= b;
      top_vec = vec;
      n_vectored++;
      if (s != mcs_pkg::SRC_T2) flags &= ~b;
    end
  endfunction

  function automatic logic advance_t01(inout logic [15:0] cnt, input logic [3:0] mode,
                                       input logic run, input logic [3:0] cyc,
                                       inout logic err);
    logic [7:0]  lo, hi;
    logic [16:0] t;
    logic        ovf;
    lo = cnt[7:0];
    hi = cnt[15:8];
    ovf = 1'b0;
    if (run) begin
      if (mode[3:2] != 2'b00 || mode[1:0] == mcs_pkg::TMODE_SPLIT) begin
        err = 1'b1;
      end else begin
        case (mcs_pkg::tmode_e'(mode[1:0]))
          mcs_pkg::TMODE_13BIT: begin
            t = {4'b0, hi, lo[4:0]} + cyc;
            ovf = t > 17'h1FFF;
            lo = {lo[7:5], t[4:0]};
            hi = t[12:5];
          end
          mcs_pkg::TMODE_16BIT: begin
            t = {1'b0, hi, lo} + cyc;
            ovf = t[16];
            lo = t[7:0];
            hi = t[15:8];
          end
          default: begin
            t = {9'b0, lo} + cyc;
            ovf = t > 17'hFF;
            if (ovf) t = t + hi;
            lo = t[7:0];
          end
        endcase
        cnt = {hi, lo};
      end
    end
    return ovf;
  endfunction

  function automatic mcs_pkg::out_t step_timer_unit(input mcs_pkg::in_t req);
    mcs_pkg::out_t r;
    logic [1:0]    pins;
    logic          err;
    logic [17:0]   t2;
    logic [2:0]    popped;
    acc = '0;
    top_vec = '0;
    err = 1'b0;
    pins = {req.int1_pin, req.int0_pin};
    if (req.reti && stk_lvl > 0) begin
      stk_lvl--;
      popped = svc_stack[stk_lvl];
      if (popped < mcs_pkg::SRC_COUNT) in_svc[popped] = 1'b0;
    end
    if (req.clear_timer2_flag) flags[mcs_pkg::SRC_T2] = 1'b0;
    for (int n = 0; n < 2; n++) begin
      if (sh_edge[n] ? (prev_pins[n] && !pins[n]) : !pins[n]) flags[n] = 1'b1;
    end
    prev_pins = pins;
    accept_source(mcs_pkg::SRC_EXT0);
    accept_source(mcs_pkg::SRC_EXT1);
    if (advance_t01(cnt0, sh_tmod[3:0], sh_run[0], req.cycles, err)) begin
      flags[mcs_pkg::SRC_T0] = 1'b1;
      n_ovf++;
    end
    if (advance_t01(cnt1, sh_tmod[7:4], sh_run[1], req.cycles, err)) begin
      flags[mcs_pkg::SRC_T1] = 1'b1;
      n_ovf++;
    end
    if (sh_run[2]) begin
      t2 = {2'b0, cnt2} + req.cycles;
      if (t2[16]) begin
        flags[mcs_pkg::SRC_T2] = 1'b1;
        t2 = t2 + sh_reload;
        n_ovf++;
      end
      cnt2 = t2[15:0];
    end
    accept_source(mcs_pkg::SRC_T0);
    accept_source(mcs_pkg::SRC_T1);
    accept_source(mcs_pkg::SRC_T2);
    if (err) n_mode_err++;
    r.accepted_mask = acc;
    r.top_vector    = top_vec;
    r.pending_flags = flags;
    r.timer0_value  = cnt0;
    r.timer1_value  = cnt1;
    r.timer2_value  = cnt2;
    r.mode_error    = err;
    return r;
  endfunction

  // receiver side
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      if (fail_count < REPORT_CAP)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_results.size() == 0) begin
        if (fail_count < REPORT_CAP) $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = exp_results.pop_front();
        check_field("accepted_mask", 16'(want.accepted_mask), 16'(out_o.accepted_mask));
        check_field("top_vector", 16'(want.top_vector), 16'(out_o.top_vector));
        check_field("pending_flags", 16'(want.pending_flags), 16'(out_o.pending_flags));
        check_field("timer0_value", want.timer0_value, out_o.timer0_value);
        check_field("timer1_value", want.timer1_value, out_o.timer1_value);
        check_field("timer2_value", want.timer2_value, out_o.timer2_value);
        check_field("mode_error", 16'(want.mode_error), 16'(out_o.mode_error));
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with valid still high
  task automatic send_req(input logic [3:0] cyc, input logic p0, input logic p1,
                          input logic rt, input logic clr);
    mcs_pkg::in_t req;
    req.cycles = cyc;
    req.int0_pin = p0;
    req.int1_pin = p1;
    req.reti = rt;
    req.clear_timer2_flag = clr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_results.push_back(step_timer_unit(req));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_instr(input logic full_cycles);
    logic [3:0] cyc;
    logic       rt, clr;
    if ($urandom_range(99) < 30) pin0_last = ~pin0_last;
    if ($urandom_range(99) < 30) pin1_last = ~pin1_last;
    rt = (stk_lvl > 0) ? ($urandom_range(99) < 35) : ($urandom_range(99) < 3);
    clr = flags[mcs_pkg::SRC_T2] ? ($urandom_range(99) < 30) : ($urandom_range(99) < 5);
    if (full_cycles || $urandom_range(99) < 20) cyc = 4'hF;
    else cyc = 4'($urandom_range(15));
    send_req(cyc, pin0_last, pin1_last, rt, clr);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (exp_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [mcs_pkg::CFG_INDEX_W-1:0] idx, input logic [15:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic [15:0] tm_d, input logic [15:0] run_d,
                              input logic [15:0] es_d, input logic [15:0] ie_d,
                              input logic [15:0] rel_d);
    write_reg(mcs_pkg::CFG_TIMER_MODE, tm_d);
    write_reg(mcs_pkg::CFG_RUN_ENABLES, run_d);
    write_reg(mcs_pkg::CFG_EDGE_SELECT, es_d);
    write_reg(mcs_pkg::CFG_INT_ENABLE, ie_d);
    write_reg(mcs_pkg::CFG_T2_RELOAD, rel_d);
    // unmapped index, must be ignored
    write_reg(IDX_W'($urandom_range(IDX_TOP, IDX_UNMAPPED)), 16'($urandom));
    cfg_we_i <= 1'b0;
    sh_tmod   = tm_d[7:0];
    sh_run    = run_d[2:0];
    sh_edge   = es_d[1:0];
    sh_ie     = ie_d[7:0];
    sh_reload = rel_d;
    n_cfg++;
  endtask

  task automatic test_directed();
    write_config(16'h0020, 16'h0007, 16'h0001, 16'h00FF, 16'hFFFF);
    send_req(4'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_req(4'd15, 1'b1, 1'b1, 1'b0, 1'b0);
    // falling edge on int0, then held low
    send_req(4'd7, 1'b0, 1'b1, 1'b0, 1'b0);
    send_req(4'd3, 1'b0, 1'b1, 1'b0, 1'b0);
    // low level on int1 nests over ext0, then stays pending while in service
    send_req(4'd2, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(4'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(4'd4, 1'b0, 1'b0, 1'b1, 1'b0);
    send_req(4'd5, 1'b1, 1'b1, 1'b1, 1'b0);
    send_req(4'd6, 1'b1, 1'b1, 1'b1, 1'b0);
    // return with empty stack
    send_req(4'd9, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_idle();
    // global enable off
    write_config(16'h0020, 16'h0007, 16'h0002, 16'h007F, 16'h0000);
    send_req(4'd15, 1'b0, 1'b1, 1'b0, 1'b0);
    send_req(4'd15, 1'b1, 1'b0, 1'b0, 1'b0);
    wait_idle();
    write_config(16'h0020, 16'h0007, 16'h0002, 16'h0080, 16'h0000);
    send_req(4'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    wait_idle();
    write_config(16'h0020, 16'h0007, 16'h0002, 16'h00FF, 16'h0000);
    send_req(4'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    wait_idle();
    // gate with split mode on timer 0, split mode on timer 1
    write_config(16'h003B, 16'h0003, 16'h0000, 16'h00FF, 16'h0000);
    send_req(4'd15, 1'b1, 1'b1, 1'b1, 1'b0);
    send_req(4'd8, 1'b1, 1'b1, 1'b1, 1'b0);
    wait_idle();
    // counter select on both timers
    write_config(16'h004C, 16'h0003, 16'h0000, 16'h00FF, 16'h0000);
    send_req(4'd3, 1'b1, 1'b1, 1'b0, 1'b0);
    wait_idle();
    // bad modes on stopped timers
    write_config(16'h00FF, 16'h0000, 16'h0003, 16'h00FF, 16'h0000);
    send_req(4'd15, 1'b1, 1'b1, 1'b0, 1'b0);
    wait_idle();
    write_config(16'h0012, 16'h0003, 16'h0000, 16'h00FF, 16'h0000);
    repeat (4) send_req(4'd15, 1'b1, 1'b1, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random(input int n_blocks, input int per_block);
    logic [3:0]  tm_lo, tm_hi;
    logic [15:0] rel;
    for (int blk = 0; blk < n_blocks; blk++) begin
      if (blk == 0) begin
        write_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end else if (blk == 1) begin
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else begin
        tm_lo = ($urandom_range(99) < 80) ? 4'($urandom_range(2)) : 4'($urandom_range(15));
        tm_hi = ($urandom_range(99) < 80) ? 4'($urandom_range(2)) : 4'($urandom_range(15));
        case ($urandom_range(3))
          0:       rel = 16'h0000;
          1:       rel = 16'hFFFF;
          2:       rel = {8'hFF, 8'($urandom)};
          default: rel = 16'($urandom);
        endcase
        write_config({8'($urandom), tm_hi, tm_lo},
                     16'($urandom),
                     16'($urandom),
                     ($urandom_range(99) < 85) ? (16'($urandom) | 16'h0080) : 16'($urandom),
                     rel);
      end
      repeat (per_block) send_random_instr(1'b0);
      wait_idle();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_i = '0;
    out_ready_i = 1'b0;
    sh_tmod = '0;
    sh_run = '0;
    sh_edge = '0;
    sh_ie = '0;
    sh_reload = '0;
    cnt0 = '0;
    cnt1 = '0;
    cnt2 = '0;
    flags = '0;
    in_svc = '0;
    acc = '0;
    top_vec = '0;
    prev_pins = 2'b11;
    stk_lvl = 0;
    pin0_last = 1'b1;
    pin1_last = 1'b1;
    fail_count = 0;
    n_sent = 0;
    n_cfg = 0;
    n_vectored = 0;
    n_ovf = 0;
    n_mode_err = 0;
    send_idle_pct = 9;
    recv_idle_pct = 86;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(11, 50);
    send_idle_pct = 86;
    recv_idle_pct = 9;
    test_random(11, 50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(11, 50);
    wait_idle();

    $display("Ran %0d instructions across %0d register settings under three stall patterns",
             n_sent, n_cfg);
    $display("Predicted %0d vectored interrupts, %0d timer overflows, %0d mode-error steps",
             n_vectored, n_ovf, n_mode_err);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
sv/mcs_pkg.sv
sv/mcs_timer01.sv
sv/mcs_irq.sv
sv/mcs51_timers_and_interrupts.sv
verif/tb_mcs51_timers_and_interrupts.sv
